@@ sv/dhcprx_pkg.sv @@
// Shared types, codes and constants of the DHCP client receive block.
package dhcprx_pkg;

  localparam logic [3:0] OC_SHORT      = 4'd0;
  localparam logic [3:0] OC_BAD_OP     = 4'd1;
  localparam logic [3:0] OC_BAD_XID    = 4'd2;
  localparam logic [3:0] OC_MALFORMED  = 4'd3;
  localparam logic [3:0] OC_NO_OFFER   = 4'd4;
  localparam logic [3:0] OC_REQUEST    = 4'd5;
  localparam logic [3:0] OC_NAK        = 4'd6;
  localparam logic [3:0] OC_BOUND      = 4'd7;
  localparam logic [3:0] OC_IGNORED    = 4'd8;
  localparam logic [3:0] OC_IGN_BOUND  = 4'd9;
  localparam logic [3:0] OC_DISCOVER   = 4'd10;

  localparam logic [1:0] PH_DISCOVER = 2'd0;
  localparam logic [1:0] PH_REQUEST  = 2'd1;
  localparam logic [1:0] PH_BOUND    = 2'd2;

  localparam logic [31:0] OP_WORD = 32'h0201_0600;
  localparam int unsigned MIN_LEN = 48 + 192 + 4;
  localparam int unsigned OPT_START = 240;
  localparam int unsigned MSG_TYPE_POS = OPT_START + 2;

  localparam logic [7:0] MSG_OFFER    = 8'h02;
  localparam logic [7:0] MSG_ACK      = 8'h05;
  localparam logic [7:0] MSG_NAK      = 8'h06;
  localparam logic [7:0] OPT_PAD      = 8'h00;
  localparam logic [7:0] OPT_END      = 8'hff;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_NETMASK  = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [1:0]  client_phase;
    logic [15:0] discover_secs;
    logic [31:0] offered_ip;
    logic [31:0] server_ip;
    logic [31:0] lease_netmask;
    logic [31:0] lease_gateway;
    logic [31:0] lease_dns;
  } result_t;

  function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = word[31:24];
      2'd1:    b = word[23:16];
      2'd2:    b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ sv/dhcprx_core.sv @@
// Client phase, header checks, option walker and packet judgment.
module dhcprx_core import dhcprx_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_xid_i,
  input  logic        in_fire_i,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned NOS_W = $clog2(MAX_PACKET_BYTES + 257);

  logic [31:0]      xid_q, xid_d;
  logic [1:0]       phase_q, phase_d;
  logic [15:0]      secs_q, secs_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             op_ok_q, op_ok_d, xid_ok_q, xid_ok_d, opt_ok_q, opt_ok_d;
  logic [7:0]       msg_q, msg_d;
  logic [31:0]      yaddr_q, yaddr_d, saddr_q, saddr_d;
  logic [31:0]      cap_q [3];
  logic [31:0]      cap_d [3];
  logic [POS_W-1:0] win_start_q [3];
  logic [POS_W-1:0] win_start_d [3];
  logic [2:0]       win_open_q, win_open_d;
  logic [NOS_W-1:0] nos_q, nos_d;
  logic             walk_active_q, walk_active_d, walk_len_q, walk_len_d;

  logic [POS_W-1:0] win_diff [3];
  logic [2:0]       in_win;
  logic [1:0]       opt_slot;
  logic             opt_hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_diff[i] = pos_q - win_start_q[i];
      in_win[i]   = win_open_q[i] && (pos_q >= win_start_q[i]) && (win_diff[i] < POS_W'(4));
    end
  end

  always_comb begin
    opt_hit  = 1'b1;
    opt_slot = 2'd0;
    case (rx_byte_i)
      OPT_NETMASK: opt_slot = 2'd0;
      OPT_ROUTER:  opt_slot = 2'd1;
      OPT_DNS:     opt_slot = 2'd2;
      default:     opt_hit  = 1'b0;
    endcase
  end

  always_comb begin
    xid_d         = cfg_we_i ? cfg_xid_i : xid_q;
    phase_d       = phase_q;
    secs_d        = secs_q;
    pos_d         = pos_q;
    op_ok_d       = op_ok_q;
    xid_ok_d      = xid_ok_q;
    opt_ok_d      = opt_ok_q;
    msg_d         = msg_q;
    yaddr_d       = yaddr_q;
    saddr_d       = saddr_q;
    cap_d         = cap_q;
    win_start_d   = win_start_q;
    win_open_d    = win_open_q;
    nos_d         = nos_q;
    walk_active_d = walk_active_q;
    walk_len_d    = walk_len_q;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (in_fire_i) begin
      if (operation_i) begin
        if (phase_q == PH_DISCOVER) begin
          res_valid_o         = 1'b1;
          res_o.outcome       = OC_DISCOVER;
          res_o.client_phase  = phase_q;
          res_o.discover_secs = secs_q;
          secs_d              = secs_q + 16'd1;
        end
      end else begin
        if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
          pos_d = pos_q + POS_W'(1);
          if (pos_q < POS_W'(4)) begin
            if (rx_byte_i != byte_sel(OP_WORD, pos_q[1:0])) op_ok_d = 1'b0;
          end else if (pos_q < POS_W'(8)) begin
            if (rx_byte_i != byte_sel(xid_q, pos_q[1:0])) xid_ok_d = 1'b0;
          end else if (pos_q >= POS_W'(16) && pos_q < POS_W'(20)) begin
            yaddr_d = {yaddr_q[23:0], rx_byte_i};
          end else if (pos_q >= POS_W'(20) && pos_q < POS_W'(24)) begin
            saddr_d = {saddr_q[23:0], rx_byte_i};
          end else if (pos_q == POS_W'(OPT_START)) begin
            if (rx_byte_i != OPT_MSG_TYPE) opt_ok_d = 1'b0;
          end else if (pos_q == POS_W'(MSG_TYPE_POS)) begin
            msg_d = rx_byte_i;
          end

          for (int i = 0; i < 3; i++) begin
            if (in_win[i]) begin
              cap_d[i] = cap_q[i] | ({24'd0, rx_byte_i} << {~win_diff[i][1:0], 3'b000});
              if (win_diff[i] == POS_W'(3)) win_open_d[i] = 1'b0;
            end
          end

          if (walk_len_q) begin
            nos_d         = NOS_W'(pos_q) + NOS_W'(rx_byte_i) + NOS_W'(1);
            walk_active_d = 1'b1;
            walk_len_d    = 1'b0;
          end else if (walk_active_q && NOS_W'(pos_q) == nos_q) begin
            if (rx_byte_i == OPT_END) begin
              walk_active_d = 1'b0;
            end else if (rx_byte_i == OPT_PAD) begin
              nos_d = NOS_W'(pos_q) + NOS_W'(1);
            end else begin
              if (opt_hit) begin
                cap_d[opt_slot]       = '0;
                win_start_d[opt_slot] = pos_q + POS_W'(2);
                win_open_d[opt_slot]  = 1'b1;
              end
              walk_len_d = 1'b1;
            end
          end
        end else begin
          pos_d = POS_W'(MAX_PACKET_BYTES + 1);
        end

        if (last_i) begin
          res_valid_o = 1'b1;
          if (phase_q == PH_BOUND) begin
            res_o.outcome = OC_IGN_BOUND;
          end else if (pos_d < POS_W'(MIN_LEN) || pos_d > POS_W'(MAX_PACKET_BYTES)) begin
            res_o.outcome = OC_SHORT;
          end else if (!op_ok_d) begin
            res_o.outcome = OC_BAD_OP;
          end else if (!xid_ok_d) begin
            res_o.outcome = OC_BAD_XID;
          end else if (!opt_ok_d) begin
            res_o.outcome = OC_MALFORMED;
          end else if (phase_q == PH_DISCOVER) begin
            if (msg_d != MSG_OFFER) begin
              res_o.outcome = OC_NO_OFFER;
            end else begin
              res_o.outcome    = OC_REQUEST;
              phase_d          = PH_REQUEST;
              res_o.offered_ip = yaddr_d;
              res_o.server_ip  = saddr_d;
            end
          end else if (msg_d == MSG_NAK) begin
            res_o.outcome = OC_NAK;
            phase_d       = PH_DISCOVER;
          end else if (msg_d == MSG_ACK) begin
            res_o.outcome       = OC_BOUND;
            phase_d             = PH_BOUND;
            res_o.offered_ip    = yaddr_d;
            res_o.server_ip     = saddr_d;
            res_o.lease_netmask = cap_d[0];
            res_o.lease_gateway = cap_d[1];
            res_o.lease_dns     = cap_d[2];
          end else begin
            res_o.outcome = OC_IGNORED;
          end
          res_o.client_phase = phase_d;

          pos_d         = '0;
          op_ok_d       = 1'b1;
          xid_ok_d      = 1'b1;
          opt_ok_d      = 1'b1;
          msg_d         = '0;
          yaddr_d       = '0;
          saddr_d       = '0;
          for (int i = 0; i < 3; i++) begin
            cap_d[i]       = '0;
            win_start_d[i] = '0;
          end
          win_open_d    = '0;
          nos_d         = NOS_W'(OPT_START);
          walk_active_d = 1'b1;
          walk_len_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q         <= '0;
      phase_q       <= PH_DISCOVER;
      secs_q        <= '0;
      pos_q         <= '0;
      op_ok_q       <= 1'b1;
      xid_ok_q      <= 1'b1;
      opt_ok_q      <= 1'b1;
      msg_q         <= '0;
      yaddr_q       <= '0;
      saddr_q       <= '0;
      for (int i = 0; i < 3; i++) begin
        cap_q[i]       <= '0;
        win_start_q[i] <= '0;
      end
      win_open_q    <= '0;
      nos_q         <= NOS_W'(OPT_START);
      walk_active_q <= 1'b1;
      walk_len_q    <= 1'b0;
    end else begin
      xid_q         <= xid_d;
      phase_q       <= phase_d;
      secs_q        <= secs_d;
      pos_q         <= pos_d;
      op_ok_q       <= op_ok_d;
      xid_ok_q      <= xid_ok_d;
      opt_ok_q      <= opt_ok_d;
      msg_q         <= msg_d;
      yaddr_q       <= yaddr_d;
      saddr_q       <= saddr_d;
      cap_q         <= cap_d;
      win_start_q   <= win_start_d;
      win_open_q    <= win_open_d;
      nos_q         <= nos_d;
      walk_active_q <= walk_active_d;
      walk_len_q    <= walk_len_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && !operation_i && last_i |=> pos_q == '0 && walk_active_q && !walk_len_q)
    else $error("Receiver not cleared after the last byte of a packet.");

  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && operation_i && phase_q != PH_DISCOVER |=> $stable(secs_q) && $stable(phase_q))
    else $error("Tick outside discover changed the client state.");

  a_bound_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.outcome == OC_BOUND |=> phase_q == PH_BOUND)
    else $error("Bound outcome without moving to the bound phase.");

endmodule

@@ sv/dhcp_client_rx_state_machine_top.sv @@
// Top level of the DHCP client receive block with its output buffer.
//
//   channel  handshake                  payload
//   cfg      cfg_valid_i / cfg_ready_o  cfg_transaction_id_i
//   in       in_valid_i  / in_ready_o   operation_i, rx_byte_i, last_i
//   out      out_valid_o / out_ready_i  outcome_o ... lease_dns_o
//
// Every item is processed in the cycle it is accepted; its result, if any, is
// registered, and one item per cycle is sustained while the input is not stalled.
// A two-entry output buffer lets input continue while one result waits.
// Input stalls only when both output entries hold results.
// Reset is asynchronous and puts the client in discover with all checks armed.
module dhcp_client_rx_state_machine_top import dhcprx_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_transaction_id_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  outcome_o,
  output logic [1:0]  client_phase_o,
  output logic [15:0] discover_secs_o,
  output logic [31:0] offered_ip_o,
  output logic [31:0] server_ip_o,
  output logic [31:0] lease_netmask_o,
  output logic [31:0] lease_gateway_o,
  output logic [31:0] lease_dns_o
);

  logic    in_fire, push, pop;
  logic    res_valid;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign push        = res_valid;
  assign pop         = out_valid_q && out_ready_i;

  dhcprx_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_xid_i   (cfg_transaction_id_i),
    .in_fire_i   (in_fire),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .last_i      (last_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = out_q.outcome;
  assign client_phase_o  = out_q.client_phase;
  assign discover_secs_o = out_q.discover_secs;
  assign offered_ip_o    = out_q.offered_ip;
  assign server_ip_o     = out_q.server_ip;
  assign lease_netmask_o = out_q.lease_netmask;
  assign lease_gateway_o = out_q.lease_gateway;
  assign lease_dns_o     = out_q.lease_dns;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Second buffer entry holds an item while the first is empty.");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("Result lost while the output was stalled.");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_valid_q && !skid_valid_q)
    else $error("Buffered result not moved forward after the output drained.");

endmodule

@@ sim/dhcprx_reply_monitor.sv @@
// Watches the DHCP receive block channels, predicts every result and compares it.
`timescale 1ns / 1ps

module dhcprx_reply_monitor import dhcprx_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_transaction_id_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  outcome_i,
  input  logic [1:0]  client_phase_i,
  input  logic [15:0] discover_secs_i,
  input  logic [31:0] offered_ip_i,
  input  logic [31:0] server_ip_i,
  input  logic [31:0] lease_netmask_i,
  input  logic [31:0] lease_gateway_i,
  input  logic [31:0] lease_dns_i,
  output int          mismatches_o,
  output int          awaited_o,
  output int          results_o
);

  logic [31:0] xid;
  logic [1:0]  phase;
  logic [15:0] secs;
  int          pos;
  logic        op_ok;
  logic        xid_ok;
  logic        opt_ok;
  logic [7:0]  msg_type;
  logic [31:0] yiaddr;
  logic [31:0] siaddr;
  logic [31:0] grab [0:2];
  int          opt_at;
  logic        walk_on;
  logic        walk_len;
  int          win_at [0:2];
  logic        win_open [0:2];
  result_t     awaited_replies [$];

  function automatic int option_slot(input logic [7:0] code);
    case (code)
      OPT_NETMASK: return 0;
      OPT_ROUTER:  return 1;
      OPT_DNS:     return 2;
      default:     return -1;
    endcase
  endfunction

  task automatic clear_packet();
    int k;
    pos = 0;
    op_ok = 1'b1;
    xid_ok = 1'b1;
    opt_ok = 1'b1;
    msg_type = '0;
    yiaddr = '0;
    siaddr = '0;
    for (k = 0; k < 3; k++) begin
      grab[k] = '0;
      win_at[k] = 0;
      win_open[k] = 1'b0;
    end
    opt_at = OPT_START;
    walk_on = 1'b1;
    walk_len = 1'b0;
  endtask

  task automatic absorb_byte(input int p, input logic [7:0] b);
    int k;
    int slot;
    if (p < 4) begin
      if (b != 8'(OP_WORD >> (24 - 8 * p))) op_ok = 1'b0;
    end else if (p < 8) begin
      if (b != 8'(xid >> (24 - 8 * (p - 4)))) xid_ok = 1'b0;
    end else if (p >= 16 && p < 20) begin
      yiaddr = {yiaddr[23:0], b};
    end else if (p >= 20 && p < 24) begin
      siaddr = {siaddr[23:0], b};
    end else if (p == OPT_START) begin
      if (b != OPT_MSG_TYPE) opt_ok = 1'b0;
    end else if (p == MSG_TYPE_POS) begin
      msg_type = b;
    end

    for (k = 0; k < 3; k++) begin
      if (win_open[k] && p >= win_at[k] && p < win_at[k] + 4) begin
        grab[k] = grab[k] | (32'(b) << (8 * (3 - (p - win_at[k]))));
        if (p == win_at[k] + 3) win_open[k] = 1'b0;
      end
    end

    if (walk_len) begin
      opt_at = p + 1 + int'(b);
      walk_len = 1'b0;
    end else if (walk_on && p == opt_at) begin
      if (b == OPT_END) begin
        walk_on = 1'b0;
      end else if (b == OPT_PAD) begin
        opt_at = p + 1;
      end else begin
        slot = option_slot(b);
        if (slot >= 0) begin
          grab[slot] = '0;
          win_at[slot] = p + 2;
          win_open[slot] = 1'b1;
        end
        walk_len = 1'b1;
      end
    end
  endtask

  task automatic predict_item(input logic op, input logic [7:0] b, input logic last);
    result_t r;
    int len;
    r = '0;
    if (op) begin
      if (phase != PH_DISCOVER) return;
      r.outcome = OC_DISCOVER;
      r.discover_secs = secs;
      secs = secs + 16'd1;
    end else begin
      if (pos < MAX_PACKET_BYTES) begin
        absorb_byte(pos, b);
        pos = pos + 1;
      end else begin
        pos = MAX_PACKET_BYTES + 1;
      end
      if (!last) return;
      len = pos;
      if (phase == PH_BOUND) begin
        r.outcome = OC_IGN_BOUND;
      end else if (len < MIN_LEN || len > MAX_PACKET_BYTES) begin
        r.outcome = OC_SHORT;
      end else if (!op_ok) begin
        r.outcome = OC_BAD_OP;
      end else if (!xid_ok) begin
        r.outcome = OC_BAD_XID;
      end else if (!opt_ok) begin
        r.outcome = OC_MALFORMED;
      end else if (phase == PH_DISCOVER) begin
        if (msg_type != MSG_OFFER) begin
          r.outcome = OC_NO_OFFER;
        end else begin
          r.outcome = OC_REQUEST;
          phase = PH_REQUEST;
          r.offered_ip = yiaddr;
          r.server_ip = siaddr;
        end
      end else if (msg_type == MSG_NAK) begin
        r.outcome = OC_NAK;
        phase = PH_DISCOVER;
      end else if (msg_type == MSG_ACK) begin
        r.outcome = OC_BOUND;
        phase = PH_BOUND;
        r.offered_ip = yiaddr;
        r.server_ip = siaddr;
        r.lease_netmask = grab[0];
        r.lease_gateway = grab[1];
        r.lease_dns = grab[2];
      end else begin
        r.outcome = OC_IGNORED;
      end
      clear_packet();
    end
    r.client_phase = phase;
    awaited_replies.push_back(r);
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    int bad;
    if (!rst_ni) begin
      xid = '0;
      phase = PH_DISCOVER;
      secs = '0;
      clear_packet();
      awaited_replies.delete();
      mismatches_o <= 0;
      awaited_o <= 0;
      results_o <= 0;
    end else begin
      bad = 0;
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("result with outcome %0d arrived with nothing expected", outcome_i);
          bad = 1;
        end else begin
          want = awaited_replies.pop_front();
          bad = field_differs("outcome", 32'(want.outcome), 32'(outcome_i))
              + field_differs("client_phase", 32'(want.client_phase), 32'(client_phase_i))
              + field_differs("discover_secs", 32'(want.discover_secs), 32'(discover_secs_i))
              + field_differs("offered_ip", want.offered_ip, offered_ip_i)
              + field_differs("server_ip", want.server_ip, server_ip_i)
              + field_differs("lease_netmask", want.lease_netmask, lease_netmask_i)
              + field_differs("lease_gateway", want.lease_gateway, lease_gateway_i)
              + field_differs("lease_dns", want.lease_dns, lease_dns_i);
        end
        results_o <= results_o + 1;
      end
      if (cfg_valid_i && cfg_ready_i) xid = cfg_transaction_id_i;
      if (in_valid_i && in_ready_i) predict_item(operation_i, rx_byte_i, last_i);
      mismatches_o <= mismatches_o + bad;
      awaited_o <= awaited_replies.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// Stimulus and verdict for the DHCP client receive block.
`timescale 1ns / 1ps

module testbench;
  import dhcprx_pkg::*;

  localparam int unsigned MAX_BYTES   = 512;
  localparam int          STUCK_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 64;
  localparam int          SETTLE      = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_xid = '0;
  logic        in_valid = 1'b0;
  logic        operation = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        last_flag = 1'b0;
  logic        out_ready = 1'b0;

  wire         cfg_ready;
  wire         in_ready;
  wire         out_valid;
  wire [3:0]   outcome;
  wire [1:0]   client_phase;
  wire [15:0]  discover_secs;
  wire [31:0]  offered_ip;
  wire [31:0]  server_ip;
  wire [31:0]  lease_netmask;
  wire [31:0]  lease_gateway;
  wire [31:0]  lease_dns;

  int          mismatches;
  int          awaited;
  int          results_checked;

  int          stuck_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          holdoffs_asked = 0;
  int          holdoffs_done = 0;
  logic [31:0] xid_now = '0;
  logic [7:0]  frame [$];
  int          items_sent = 0;
  int          frames_sent = 0;
  int          ticks_sent = 0;
  int          xid_writes = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dhcp_client_rx_state_machine_top #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_transaction_id_i(cfg_xid),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .operation_i         (operation),
    .rx_byte_i           (rx_byte),
    .last_i              (last_flag),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .outcome_o           (outcome),
    .client_phase_o      (client_phase),
    .discover_secs_o     (discover_secs),
    .offered_ip_o        (offered_ip),
    .server_ip_o         (server_ip),
    .lease_netmask_o     (lease_netmask),
    .lease_gateway_o     (lease_gateway),
    .lease_dns_o         (lease_dns)
  );

  dhcprx_reply_monitor #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) u_monitor (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_transaction_id_i(cfg_xid),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .operation_i         (operation),
    .rx_byte_i           (rx_byte),
    .last_i              (last_flag),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .outcome_i           (outcome),
    .client_phase_i      (client_phase),
    .discover_secs_i     (discover_secs),
    .offered_ip_i        (offered_ip),
    .server_ip_i         (server_ip),
    .lease_netmask_i     (lease_netmask),
    .lease_gateway_i     (lease_gateway),
    .lease_dns_i         (lease_dns),
    .mismatches_o        (mismatches),
    .awaited_o           (awaited),
    .results_o           (results_checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // The receiver stalls at random, and on request holds off for a long stretch.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (holdoffs_asked != holdoffs_done) begin
        holdoffs_done = holdoffs_done + 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic push_item(input logic op, input logic [7:0] b, input logic last);
    int n;
    n = 0;
    while ($urandom_range(99) < send_idle_pct && n < 200) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rx_byte <= b;
    last_flag <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_tick();
    push_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
    ticks_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++) begin
      if ($urandom_range(49) == 0) send_tick();
      push_item(1'b0, frame[i], i == frame.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_xid(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_xid <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    xid_now = value;
    xid_writes++;
  endtask

  // Flaw bits break the op word, the transaction id and the first option code.
  task automatic build_reply(input int len, input logic [7:0] msg, input logic [2:0] flaws);
    int i;
    int k;
    logic [7:0] code;
    frame.delete();
    for (i = 0; i < len; i++) frame.push_back(8'($urandom_range(255)));
    for (i = 0; i < 8 && i < len; i++) begin
      frame[i] = (i < 4) ? 8'(OP_WORD >> (24 - 8 * i)) : 8'(xid_now >> (24 - 8 * (i - 4)));
    end
    if (flaws[0] && len > 3) begin
      k = $urandom_range(3);
      frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
    end
    if (flaws[1] && len > 7) begin
      k = $urandom_range(7, 4);
      frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
    end
    if (len > OPT_START) begin
      code = 8'($urandom_range(255));
      if (code == OPT_MSG_TYPE) code = OPT_PAD;
      frame[OPT_START] = flaws[2] ? code : OPT_MSG_TYPE;
    end
    if (len > OPT_START + 1) frame[OPT_START + 1] = 8'd1;
    if (len > MSG_TYPE_POS) frame[MSG_TYPE_POS] = msg;
  endtask

  task automatic push_option(input logic [7:0] code, input int dlen, input int count);
    frame.push_back(code);
    frame.push_back(8'(dlen));
    repeat (count) frame.push_back(8'($urandom_range(255)));
  endtask

  // A valid acknowledgement with a random option list for the walker.
  task automatic build_lease();
    int i;
    int dlen;
    logic [7:0] code;
    build_reply(MSG_TYPE_POS + 1, MSG_ACK, 3'b000);
    for (i = 0; i < $urandom_range(2, 8); i++) begin
      case ($urandom_range(4))
        0: frame.push_back(OPT_PAD);
        1, 2: begin
          case ($urandom_range(2))
            0:       code = OPT_NETMASK;
            1:       code = OPT_ROUTER;
            default: code = OPT_DNS;
          endcase
          dlen = $urandom_range(6);
          push_option(code, dlen, dlen);
        end
        default: begin
          dlen = $urandom_range(8);
          push_option(8'($urandom_range(7, 254)), dlen, dlen);
        end
      endcase
    end
    if ($urandom_range(3) != 0) push_option(OPT_NETMASK, 4, 4);
    if ($urandom_range(3) != 0) push_option(OPT_ROUTER, 4, 4);
    if ($urandom_range(1) == 0) begin
      push_option(OPT_DNS, 4, 2);
    end else begin
      push_option(OPT_DNS, 4, 4);
      frame.push_back(OPT_END);
      repeat ($urandom_range(12)) frame.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No idling: discover ticks, short packets and one judged reply without an offer.
    set_idling(0, 0);
    write_xid($urandom());
    send_tick();
    send_tick();
    build_reply(1, MSG_OFFER, 3'b000);
    send_frame();
    build_reply($urandom_range(2, 40), MSG_OFFER, 3'b000);
    send_frame();
    build_reply(MIN_LEN, MSG_ACK, 3'($urandom_range(7)));
    send_frame();
    drain_replies();

    // Fill the output buffer while the receiver holds off.
    holdoffs_asked <= holdoffs_asked + 1;
    repeat (6) send_tick();
    repeat (6) begin
      build_reply(1, MSG_OFFER, 3'b000);
      send_frame();
    end
    drain_replies();

    // Idle sender: an offer moves the client to request.
    write_xid($urandom());
    set_idling(84, 0);
    send_tick();
    build_reply(MIN_LEN, MSG_OFFER, 3'b000);
    send_frame();
    send_tick();
    drain_replies();

    // Stalling receiver: short packets in request, then the lease.
    write_xid(32'h0000_0000);
    set_idling(0, 84);
    repeat (20) begin
      build_reply($urandom_range(1, 3), MSG_ACK, 3'b000);
      send_frame();
    end
    build_lease();
    send_frame();
    drain_replies();

    // Light idling on both sides with the client bound.
    write_xid(32'hffff_ffff);
    set_idling(9, 9);
    repeat (30) begin
      if ($urandom_range(3) == 0) send_tick();
      build_reply($urandom_range(1, 4), 8'($urandom_range(255)), 3'($urandom_range(7)));
      send_frame();
    end

    drain_replies();
    repeat (2 * SETTLE) @(posedge clk);
    $display("Sent %0d items in %0d packets and %0d discover ticks; %0d results checked.",
             items_sent, frames_sent, ticks_sent, results_checked);
    $display("Used %0d transaction ids, four idling profiles, a held-off receiver and a lease.",
             xid_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
